// File: hdl/dohs_pkg.sv
// Shared types, constants and helpers for the damped oscillator stepper.
`default_nettype none
package dohs_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 24;
	localparam int PROD_W = 2 * DATA_W;
	localparam int MRES_W = PROD_W - FRAC_W;
	localparam int WIDE_W = MRES_W + 4;
	localparam int TIME_W = 31;
	localparam int CNT_W  = 16;
	localparam int ADDR_W = 5;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [MRES_W-1:0] mres_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// register indexes on the configuration port
	localparam logic [2:0] REG_SPRING_K      = 3'd0;
	localparam logic [2:0] REG_DAMPING_GAMMA = 3'd1;
	localparam logic [2:0] REG_TIME_STEP     = 3'd2;
	localparam logic [2:0] REG_END_TIME      = 3'd3;
	localparam logic [2:0] REG_WRITE_PERIOD  = 3'd4;
	localparam logic [2:0] REG_METHOD_SELECT = 3'd5;

	localparam word_t             RST_SPRING_K      = 32'sd16777216;
	localparam word_t             RST_DAMPING_GAMMA = 32'sd838861;
	localparam logic [TIME_W-1:0] RST_TIME_STEP     = 31'd167772;
	localparam logic [TIME_W-1:0] RST_END_TIME      = 31'd671088640;
	localparam logic [CNT_W-1:0]  RST_WRITE_PERIOD  = 16'd4;
	localparam logic              RST_METHOD_SELECT = 1'b1;

	localparam logic METHOD_HEUN = 1'b1;
	localparam logic CMD_LOAD    = 1'b1;

	typedef struct packed {
		word_t             spring_k;
		word_t             damping_gamma;
		logic [TIME_W-1:0] time_step;
		logic [TIME_W-1:0] end_time;
		logic [CNT_W-1:0]  write_period;
		logic              method_select;
	} cfg_t;

	typedef struct packed {
		word_t             energy;
		word_t             velocity;
		word_t             position;
		logic [TIME_W-1:0] time_stamp;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_E0, ST_E1, ST_E2, ST_E3, ST_E4,
		ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5,
		ST_N0, ST_N1, ST_N2, ST_N3, ST_N4,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_GV, MOP_KX, MOP_HV, MOP_HDV,
		MOP_GV1, MOP_KX1, MOP_HSX, MOP_HSV,
		MOP_V1V1, MOP_X1X1, MOP_KXX
	} mul_op_t;

	typedef struct packed {
		mul_op_t mop;
		logic    ld_acc2;
		logic    ld_acc1;
		logic    ld_dv;
		logic    ld_x1;
		logic    ld_v1;
		logic    ld_sx;
		logic    ld_pv;
		logic    ld_sv;
		logic    ld_xx;
		logic    ld_en;
		logic    commit;
		logic    push;
	} ctrl_t;

	// clamp a wide signed value to the word range
	function automatic word_t sat_word(input wide_t a);
		word_t r;
		if (a > wide_t'(WORD_MAX)) begin
			r = WORD_MAX;
		end else if (a < wide_t'(WORD_MIN)) begin
			r = WORD_MIN;
		end else begin
			r = a[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/dohs_mul.sv
// Shared signed multiplier with a registered full-width product.
`default_nettype none
module dohs_mul (
	input  wire logic                           clk,
	input  wire dohs_pkg::word_t                a,
	input  wire dohs_pkg::word_t                b,
	output logic signed [dohs_pkg::PROD_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule
`default_nettype wire

// File: hdl/dohs_core.sv
// Step sequencer and datapath registers around the shared multiplier.
`default_nettype none
module dohs_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dohs_pkg::cfg_t                cfg,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          in_cmd,
	input  wire dohs_pkg::word_t               in_pos,
	input  wire dohs_pkg::word_t               in_vel,
	input  wire logic                          out_free,
	output logic                               res_push,
	output dohs_pkg::res_t                     res
);

	dohs_pkg::state_t state_q, state_d;
	dohs_pkg::ctrl_t  ctrl;

	dohs_pkg::word_t pos_q, vel_q;
	logic [dohs_pkg::TIME_W-1:0] time_q, t0_q;
	logic [dohs_pkg::CNT_W-1:0]  cnt_q;
	logic emit_q;

	dohs_pkg::wide_t acc_q;
	dohs_pkg::word_t dv_q, x1_q, v1_q, sx_q, pv_q, sv_q, xx_q, en_q;

	dohs_pkg::word_t mul_a, mul_b, h_word, v1_d;
	logic signed [dohs_pkg::PROD_W-1:0] prod_s1;
	dohs_pkg::mres_t mres;
	dohs_pkg::wide_t e_sum;

	logic in_fire, step_go;
	logic [dohs_pkg::TIME_W:0]  t_sum;
	logic [dohs_pkg::CNT_W-1:0] per;
	logic [dohs_pkg::CNT_W:0]   cnt_inc;

	function automatic dohs_pkg::word_t half_sum(input dohs_pkg::word_t a, input dohs_pkg::word_t b);
		logic signed [dohs_pkg::DATA_W:0] s;
		s = {a[dohs_pkg::DATA_W-1], a} + {b[dohs_pkg::DATA_W-1], b};
		return s[dohs_pkg::DATA_W:1];
	endfunction

	assign in_ready = (state_q == dohs_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign step_go  = in_fire && (in_cmd != dohs_pkg::CMD_LOAD) && (time_q < cfg.end_time);

	assign h_word = dohs_pkg::word_t'({1'b0, cfg.time_step});
	assign mres   = prod_s1[dohs_pkg::PROD_W-1:dohs_pkg::FRAC_W];

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mop)
			dohs_pkg::MOP_GV: begin
				mul_a = cfg.damping_gamma; mul_b = vel_q;
			end
			dohs_pkg::MOP_KX: begin
				mul_a = cfg.spring_k; mul_b = pos_q;
			end
			dohs_pkg::MOP_HV: begin
				mul_a = h_word; mul_b = vel_q;
			end
			dohs_pkg::MOP_HDV: begin
				mul_a = h_word; mul_b = dv_q;
			end
			dohs_pkg::MOP_GV1: begin
				mul_a = cfg.damping_gamma; mul_b = v1_q;
			end
			dohs_pkg::MOP_KX1: begin
				mul_a = cfg.spring_k; mul_b = x1_q;
			end
			dohs_pkg::MOP_HSX: begin
				mul_a = h_word; mul_b = sx_q;
			end
			dohs_pkg::MOP_HSV: begin
				mul_a = h_word; mul_b = sv_q;
			end
			dohs_pkg::MOP_V1V1: begin
				mul_a = v1_q; mul_b = v1_q;
			end
			dohs_pkg::MOP_X1X1: begin
				mul_a = x1_q; mul_b = x1_q;
			end
			dohs_pkg::MOP_KXX: begin
				mul_a = cfg.spring_k; mul_b = xx_q;
			end
			default: begin
				mul_a = '0; mul_b = '0;
			end
		endcase
	end

	dohs_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dohs_pkg::ST_IDLE: if (step_go) state_d = dohs_pkg::ST_E0;
			dohs_pkg::ST_E0:   state_d = dohs_pkg::ST_E1;
			dohs_pkg::ST_E1:   state_d = dohs_pkg::ST_E2;
			dohs_pkg::ST_E2:   state_d = dohs_pkg::ST_E3;
			dohs_pkg::ST_E3:   state_d = dohs_pkg::ST_E4;
			dohs_pkg::ST_E4: begin
				if (cfg.method_select == dohs_pkg::METHOD_HEUN) begin
					state_d = dohs_pkg::ST_H0;
				end else begin
					state_d = emit_q ? dohs_pkg::ST_N0 : dohs_pkg::ST_IDLE;
				end
			end
			dohs_pkg::ST_H0:   state_d = dohs_pkg::ST_H1;
			dohs_pkg::ST_H1:   state_d = dohs_pkg::ST_H2;
			dohs_pkg::ST_H2:   state_d = dohs_pkg::ST_H3;
			dohs_pkg::ST_H3:   state_d = dohs_pkg::ST_H4;
			dohs_pkg::ST_H4:   state_d = dohs_pkg::ST_H5;
			dohs_pkg::ST_H5:   state_d = emit_q ? dohs_pkg::ST_N0 : dohs_pkg::ST_IDLE;
			dohs_pkg::ST_N0:   state_d = dohs_pkg::ST_N1;
			dohs_pkg::ST_N1:   state_d = dohs_pkg::ST_N2;
			dohs_pkg::ST_N2:   state_d = dohs_pkg::ST_N3;
			dohs_pkg::ST_N3:   state_d = dohs_pkg::ST_N4;
			dohs_pkg::ST_N4:   state_d = dohs_pkg::ST_OUT;
			dohs_pkg::ST_OUT:  if (out_free) state_d = dohs_pkg::ST_IDLE;
			default:           state_d = dohs_pkg::ST_IDLE;
		endcase
	end

	// per-state controls; a product issued in one state is read in the next
	always_comb begin
		ctrl = '0;
		ctrl.mop = dohs_pkg::MOP_NONE;
		unique case (state_q)
			dohs_pkg::ST_IDLE: ;
			dohs_pkg::ST_E0: ctrl.mop = dohs_pkg::MOP_GV;
			dohs_pkg::ST_E1: begin
				ctrl.mop = dohs_pkg::MOP_KX; ctrl.ld_acc2 = 1'b1;
			end
			dohs_pkg::ST_E2: begin
				ctrl.mop = dohs_pkg::MOP_HV; ctrl.ld_dv = 1'b1;
			end
			dohs_pkg::ST_E3: begin
				ctrl.mop = dohs_pkg::MOP_HDV; ctrl.ld_x1 = 1'b1;
			end
			dohs_pkg::ST_E4: begin
				ctrl.ld_v1  = 1'b1;
				ctrl.commit = (cfg.method_select != dohs_pkg::METHOD_HEUN);
			end
			dohs_pkg::ST_H0: begin
				ctrl.mop = dohs_pkg::MOP_GV1; ctrl.ld_sx = 1'b1;
			end
			dohs_pkg::ST_H1: begin
				ctrl.mop = dohs_pkg::MOP_KX1; ctrl.ld_acc2 = 1'b1;
			end
			dohs_pkg::ST_H2: begin
				ctrl.mop = dohs_pkg::MOP_HSX; ctrl.ld_pv = 1'b1;
			end
			dohs_pkg::ST_H3: begin
				ctrl.ld_x1 = 1'b1; ctrl.ld_sv = 1'b1;
			end
			dohs_pkg::ST_H4: ctrl.mop = dohs_pkg::MOP_HSV;
			dohs_pkg::ST_H5: begin
				ctrl.ld_v1 = 1'b1; ctrl.commit = 1'b1;
			end
			dohs_pkg::ST_N0: ctrl.mop = dohs_pkg::MOP_V1V1;
			dohs_pkg::ST_N1: begin
				ctrl.mop = dohs_pkg::MOP_X1X1; ctrl.ld_acc1 = 1'b1;
			end
			dohs_pkg::ST_N2: ctrl.ld_xx = 1'b1;
			dohs_pkg::ST_N3: ctrl.mop = dohs_pkg::MOP_KXX;
			dohs_pkg::ST_N4: ctrl.ld_en = 1'b1;
			dohs_pkg::ST_OUT: ctrl.push = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dohs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign v1_d    = dohs_pkg::sat_word(dohs_pkg::wide_t'(vel_q) + dohs_pkg::wide_t'(mres));
	assign e_sum   = dohs_pkg::wide_t'(acc_q) + dohs_pkg::wide_t'(mres);
	assign t_sum   = {1'b0, time_q} + {1'b0, cfg.time_step};
	assign per     = (cfg.write_period == '0) ? dohs_pkg::CNT_W'(1) : cfg.write_period;
	assign cnt_inc = {1'b0, cnt_q} + (dohs_pkg::CNT_W+1)'(1);

	// architectural state: position, velocity, time, step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			vel_q  <= '0;
			time_q <= '0;
			cnt_q  <= '0;
			emit_q <= 1'b0;
		end else begin
			if (in_fire && (in_cmd == dohs_pkg::CMD_LOAD)) begin
				pos_q  <= in_pos;
				vel_q  <= in_vel;
				time_q <= '0;
				cnt_q  <= '0;
			end else if (step_go) begin
				time_q <= t_sum[dohs_pkg::TIME_W] ? dohs_pkg::TIME_MAX
					: t_sum[dohs_pkg::TIME_W-1:0];
				emit_q <= (cnt_q == '0);
				cnt_q  <= (cnt_inc >= {1'b0, per}) ? '0 : cnt_inc[dohs_pkg::CNT_W-1:0];
			end
			if (ctrl.commit) begin
				pos_q <= x1_q;
				vel_q <= v1_d;
			end
		end
	end

	// working registers of one step
	always_ff @(posedge clk) begin
		if (step_go) t0_q <= time_q;
		if (ctrl.ld_acc2) acc_q <= dohs_pkg::wide_t'(mres) + dohs_pkg::wide_t'(mres);
		if (ctrl.ld_acc1) acc_q <= dohs_pkg::wide_t'(mres);
		if (ctrl.ld_dv) dv_q <= dohs_pkg::sat_word(-(acc_q + dohs_pkg::wide_t'(mres)));
		if (ctrl.ld_pv) pv_q <= dohs_pkg::sat_word(-(acc_q + dohs_pkg::wide_t'(mres)));
		if (ctrl.ld_x1) x1_q <= dohs_pkg::sat_word(dohs_pkg::wide_t'(pos_q) + dohs_pkg::wide_t'(mres));
		if (ctrl.ld_v1) v1_q <= v1_d;
		if (ctrl.ld_sx) sx_q <= half_sum(vel_q, v1_q);
		if (ctrl.ld_sv) sv_q <= half_sum(dv_q, pv_q);
		if (ctrl.ld_xx) xx_q <= dohs_pkg::sat_word(dohs_pkg::wide_t'(mres));
		if (ctrl.ld_en) en_q <= dohs_pkg::sat_word(e_sum >>> 1);
	end

	assign res_push       = ctrl.push;
	assign res.time_stamp = t0_q;
	assign res.position   = x1_q;
	assign res.velocity   = v1_q;
	assign res.energy     = en_q;

endmodule
`default_nettype wire

// File: hdl/damped_oscillator_heun_stepper.sv
// Top level: configuration registers, stream ports and result register of the stepper.
// A load or a dropped step keeps the sequencer idle; a step runs the Euler states, then
// the Heun states if selected, then energy and hand-off when it reports a result.
// Throughput: a load or a dropped step every cycle while idle; a new step waits for
// idle, shares the one 32x32 multiplier, and an untaken result holds the hand-off.
// Reset (arst_n low, asynchronous): registers take their documented defaults, state,
// time and step count clear, and no result is pending.
`default_nettype none
module damped_oscillator_heun_stepper (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dohs_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	// request stream
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [63:0]                  s_tdata,  // load_position[31:0], load_velocity[63:32]
	input  wire logic [0:0]                   s_tuser,  // cmd[0]
	// result stream
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [127:0]                      m_tdata   // time_stamp[30:0], position[62:31],
	                                                    // velocity[94:63], energy[126:95], zero
);

	dohs_pkg::cfg_t cfg_q;
	dohs_pkg::res_t res, res_q;
	logic [2:0]     reg_idx;
	logic           wr_en;
	logic           res_push;
	logic           m_tvalid_q;
	logic           out_free;

	// register index is the word address; unused addresses read zero and drop writes
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spring_k      <= dohs_pkg::RST_SPRING_K;
			cfg_q.damping_gamma <= dohs_pkg::RST_DAMPING_GAMMA;
			cfg_q.time_step     <= dohs_pkg::RST_TIME_STEP;
			cfg_q.end_time      <= dohs_pkg::RST_END_TIME;
			cfg_q.write_period  <= dohs_pkg::RST_WRITE_PERIOD;
			cfg_q.method_select <= dohs_pkg::RST_METHOD_SELECT;
		end else if (wr_en) begin
			unique case (reg_idx)
				dohs_pkg::REG_SPRING_K:      cfg_q.spring_k      <= pwdata;
				dohs_pkg::REG_DAMPING_GAMMA: cfg_q.damping_gamma <= pwdata;
				dohs_pkg::REG_TIME_STEP:     cfg_q.time_step     <= pwdata[dohs_pkg::TIME_W-1:0];
				dohs_pkg::REG_END_TIME:      cfg_q.end_time      <= pwdata[dohs_pkg::TIME_W-1:0];
				dohs_pkg::REG_WRITE_PERIOD:  cfg_q.write_period  <= pwdata[dohs_pkg::CNT_W-1:0];
				dohs_pkg::REG_METHOD_SELECT: cfg_q.method_select <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back, zero-extending the narrow registers
	always_comb begin
		unique case (reg_idx)
			dohs_pkg::REG_SPRING_K:      prdata = cfg_q.spring_k;
			dohs_pkg::REG_DAMPING_GAMMA: prdata = cfg_q.damping_gamma;
			dohs_pkg::REG_TIME_STEP:     prdata = {1'b0, cfg_q.time_step};
			dohs_pkg::REG_END_TIME:      prdata = {1'b0, cfg_q.end_time};
			dohs_pkg::REG_WRITE_PERIOD:  prdata = {16'd0, cfg_q.write_period};
			dohs_pkg::REG_METHOD_SELECT: prdata = {31'd0, cfg_q.method_select};
			default:                     prdata = '0;
		endcase
	end

	// the result register frees the core: a new request may be taken while it waits
	assign out_free = !m_tvalid_q || m_tready;

	dohs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser[0]),
		.in_pos   (s_tdata[31:0]),
		.in_vel   (s_tdata[63:32]),
		.out_free (out_free),
		.res_push (res_push),
		.res      (res)
	);

	// hold the result until taken; advance only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.energy, res_q.velocity, res_q.position, res_q.time_stamp};

endmodule
`default_nettype wire

// File: hdl/dohs_checker.sv
// Port-level checks for the stepper and the bind that attaches them.
`default_nettype none
module dohs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic [0:0]                  s_tuser,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [127:0]                m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a load leaves the block ready in the following cycle
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> s_tready)
		else $error("load did not return to ready");

	// a load never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !$rose(m_tvalid))
		else $error("result appeared after a load");

	// a new result only follows a busy cycle of the sequencer
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a step in progress");

endmodule

bind damped_oscillator_heun_stepper dohs_checker u_dohs_checker (.*);
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the damped oscillator stepper: stream stimulus, APB setup, scoreboard.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic            CMD_STEP   = ~dohs_pkg::CMD_LOAD;
	localparam dohs_pkg::word_t Q_ONE      = 32'sh0100_0000;	// 1.0 in Q8.24
	localparam int              SETTLE_CYC = 40;	// outlasts the worst step plus energy
	localparam int              RAND_REQS  = 950;

	typedef struct {
		logic            cmd;
		dohs_pkg::word_t pos;
		dohs_pkg::word_t vel;
	} osc_req_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [dohs_pkg::ADDR_W-1:0] paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [63:0]   s_tdata  = '0;	// load_position[31:0], load_velocity[63:32]
	logic [0:0]    s_tuser  = '0;	// cmd[0]
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [127:0]  m_tdata;		// time_stamp[30:0], position[62:31], velocity[94:63],
					// energy[126:95], zero

	// Requests waiting to be sent, and results the oscillator model says must come back
	osc_req_t       pending_reqs[$];
	dohs_pkg::res_t expected_results[$];

	// Model copy of the registers and of the integrator state
	dohs_pkg::word_t             model_k      = dohs_pkg::RST_SPRING_K;
	dohs_pkg::word_t             model_gamma  = dohs_pkg::RST_DAMPING_GAMMA;
	logic [dohs_pkg::TIME_W-1:0] model_h      = dohs_pkg::RST_TIME_STEP;
	logic [dohs_pkg::TIME_W-1:0] model_end    = dohs_pkg::RST_END_TIME;
	logic [dohs_pkg::CNT_W-1:0]  model_period = dohs_pkg::RST_WRITE_PERIOD;
	logic                        model_method = dohs_pkg::RST_METHOD_SELECT;
	dohs_pkg::word_t             model_pos    = '0;
	dohs_pkg::word_t             model_vel    = '0;
	logic [dohs_pkg::TIME_W-1:0] model_time   = '0;
	logic [dohs_pkg::CNT_W-1:0]  model_count  = '0;

	int mismatches      = 0;
	int loads_done      = 0;
	int steps_done      = 0;
	int steps_ignored   = 0;
	int results_checked = 0;
	int settings_used   = 1;

	logic           req_taken = 1'b0;
	int             send_gap  = 0;
	int             recv_hold = 0;
	bit             send_calm = 1'b0;
	bit             recv_calm = 1'b0;
	osc_req_t       next_req;
	dohs_pkg::res_t got_res;
	dohs_pkg::res_t want_res;

	damped_oscillator_heun_stepper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run of about 1000 requests
	initial begin
		#20_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Fixed-point arithmetic of the oscillator, carried in 64 bits so nothing overflows
	// ---------------------------------------------------------------------------------

	// Q8.24 product, rounded toward minus infinity
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> dohs_pkg::FRAC_W;
	endfunction

	function automatic longint clamp(input longint a);
		if (a > longint'(dohs_pkg::WORD_MAX)) begin
			return longint'(dohs_pkg::WORD_MAX);
		end
		if (a < longint'(dohs_pkg::WORD_MIN)) begin
			return longint'(dohs_pkg::WORD_MIN);
		end
		return a;
	endfunction

	// v' = -(2*gamma*v + k*x), saturated
	function automatic longint accel(input longint x, input longint v);
		return clamp(-(2 * qmul(longint'(model_gamma), v) + qmul(longint'(model_k), x)));
	endfunction

	// Apply one accepted request to the model; queue the result it must produce, if any
	function automatic void advance_model(input logic cmd, input dohs_pkg::word_t ld_pos,
			input dohs_pkg::word_t ld_vel);
		longint x, v, h, dv, pv, x1, v1, nt;
		int unsigned per, nc;
		dohs_pkg::res_t r;
		if (cmd == dohs_pkg::CMD_LOAD) begin
			model_pos   = ld_pos;
			model_vel   = ld_vel;
			model_time  = '0;
			model_count = '0;
			loads_done++;
			return;
		end
		// Past the end of the run the step is dropped entirely
		if (model_time >= model_end) begin
			steps_ignored++;
			return;
		end
		steps_done++;
		x  = longint'(model_pos);
		v  = longint'(model_vel);
		h  = longint'(model_h);
		dv = accel(x, v);
		x1 = clamp(x + qmul(h, v));
		v1 = clamp(v + qmul(h, dv));
		if (model_method == dohs_pkg::METHOD_HEUN) begin
			// Corrector: average the slope at the start with the slope at the prediction
			pv = accel(x1, v1);
			x1 = clamp(x + qmul(h, (v + v1) >>> 1));
			v1 = clamp(v + qmul(h, (dv + pv) >>> 1));
		end
		r.time_stamp = model_time;
		r.position   = dohs_pkg::word_t'(x1);
		r.velocity   = dohs_pkg::word_t'(v1);
		r.energy     = dohs_pkg::word_t'(clamp((qmul(v1, v1)
			+ qmul(longint'(model_k), clamp(qmul(x1, x1)))) >>> 1));
		model_pos = dohs_pkg::word_t'(x1);
		model_vel = dohs_pkg::word_t'(v1);

		// Time saturates at the top of its 31-bit range
		nt = longint'(model_time) + h;
		model_time = (nt > longint'(dohs_pkg::TIME_MAX)) ? dohs_pkg::TIME_MAX
			: nt[dohs_pkg::TIME_W-1:0];

		// A zero period behaves as one; a count left above a shrunk period wraps silently
		per = (model_period == '0) ? 1 : int'(model_period);
		nc  = int'(model_count) + 1;
		if (model_count == '0) begin
			expected_results.push_back(r);
		end
		model_count = (nc >= per) ? '0 : nc[dohs_pkg::CNT_W-1:0];
	endfunction

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return $urandom_range(0, 2);
		end
		if (roll < 95) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 40);
	endfunction

	// Integrator state: mostly a few units around zero, sometimes any 32-bit value
	function automatic dohs_pkg::word_t pick_state();
		if ($urandom_range(0, 4) == 0) begin
			return dohs_pkg::word_t'($urandom);
		end
		return dohs_pkg::word_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
	endfunction

	function automatic void push_req(input logic cmd, input dohs_pkg::word_t pos,
			input dohs_pkg::word_t vel);
		osc_req_t r;
		r.cmd = cmd;
		r.pos = pos;
		r.vel = vel;
		pending_reqs.push_back(r);
	endfunction

	// Step requests carry random data, which the block must disregard
	function automatic void push_steps(input int n);
		for (int i = 0; i < n; i++) begin
			push_req(CMD_STEP, dohs_pkg::word_t'($urandom), dohs_pkg::word_t'($urandom));
		end
	endfunction

	// ---------------------------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------------------------

	// Setup cycle, then access cycle held until pready; mirror the write into the model
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= dohs_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			dohs_pkg::REG_SPRING_K:      model_k      = dohs_pkg::word_t'(val);
			dohs_pkg::REG_DAMPING_GAMMA: model_gamma  = dohs_pkg::word_t'(val);
			dohs_pkg::REG_TIME_STEP:     model_h      = val[dohs_pkg::TIME_W-1:0];
			dohs_pkg::REG_END_TIME:      model_end    = val[dohs_pkg::TIME_W-1:0];
			dohs_pkg::REG_WRITE_PERIOD:  model_period = val[dohs_pkg::CNT_W-1:0];
			dohs_pkg::REG_METHOD_SELECT: model_method = val[0];
			default: ;
		endcase
	endtask

	// Hold off until every request is sent and every result is back, then let a
	// step that reports nothing run out before the registers are touched
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// Request driver: present queued requests at the falling edge, hold until taken
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		if (s_tvalid && !req_taken) begin
			// hold the request until the block takes it
		end else if (send_gap != 0) begin
			s_tvalid <= 1'b0;
			send_gap--;
		end else if (pending_reqs.size() != 0) begin
			next_req = pending_reqs.pop_front();
			s_tuser  <= next_req.cmd;
			s_tdata  <= {next_req.vel, next_req.pos};
			s_tvalid <= 1'b1;
			send_gap = send_calm ? 0 : pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Result side back-pressure: random stalls, none while the phase is calm
	always @(negedge clk) begin
		if (recv_hold != 0) begin
			m_tready <= 1'b0;
			recv_hold--;
		end else begin
			m_tready <= 1'b1;
			if (!recv_calm && $urandom_range(0, 2) == 0) begin
				recv_hold = pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Monitor: check results against the oldest expectation, feed taken requests to the model
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got_res = dohs_pkg::res_t'(m_tdata[126:0]);
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					mismatches++;
				end else begin
					want_res = expected_results.pop_front();
					check_field("time_stamp", want_res.time_stamp, got_res.time_stamp);
					check_field("position", want_res.position, got_res.position);
					check_field("velocity", want_res.velocity, got_res.velocity);
					check_field("energy", want_res.energy, got_res.energy);
					results_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				advance_model(s_tuser[0], dohs_pkg::word_t'(s_tdata[31:0]),
					dohs_pkg::word_t'(s_tdata[63:32]));
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus sequence
	// ---------------------------------------------------------------------------------
	initial begin
		logic [31:0] val;
		int          n_seq;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings (Heun, period 4): a step from the cleared state, then the
		// corner loads, then a plain run long enough to see the period
		push_steps(1);
		push_req(dohs_pkg::CMD_LOAD, dohs_pkg::WORD_MAX, dohs_pkg::WORD_MIN);
		push_steps(4);
		push_req(dohs_pkg::CMD_LOAD, dohs_pkg::WORD_MIN, dohs_pkg::WORD_MAX);
		push_steps(1);
		push_req(dohs_pkg::CMD_LOAD, Q_ONE, '0);
		push_steps(5);
		wait_idle();

		// Euler, report every step, extreme coefficients, huge step so time saturates
		// and the third step lands past the end
		write_reg(dohs_pkg::REG_METHOD_SELECT, 32'(~dohs_pkg::METHOD_HEUN));
		write_reg(dohs_pkg::REG_WRITE_PERIOD, 32'd1);
		write_reg(dohs_pkg::REG_SPRING_K, 32'(dohs_pkg::WORD_MAX));
		write_reg(dohs_pkg::REG_DAMPING_GAMMA, 32'(dohs_pkg::WORD_MIN));
		write_reg(dohs_pkg::REG_TIME_STEP, 32'h6000_0000);
		write_reg(dohs_pkg::REG_END_TIME, 32'(dohs_pkg::TIME_MAX));
		push_req(dohs_pkg::CMD_LOAD, 32'sh0080_0000, -32'sh0080_0000);
		push_steps(3);
		wait_idle();
		settings_used++;

		// Zero end time: every step is dropped; zero period; other extremes
		write_reg(dohs_pkg::REG_END_TIME, 32'd0);
		write_reg(dohs_pkg::REG_WRITE_PERIOD, 32'd0);
		write_reg(dohs_pkg::REG_SPRING_K, 32'(dohs_pkg::WORD_MIN));
		write_reg(dohs_pkg::REG_DAMPING_GAMMA, 32'(dohs_pkg::WORD_MAX));
		write_reg(dohs_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
		push_req(dohs_pkg::CMD_LOAD, Q_ONE, Q_ONE);
		push_steps(1);
		wait_idle();
		settings_used++;

		// Leave the step count at 5 of 8, then shrink the period below it
		write_reg(dohs_pkg::REG_END_TIME, 32'(dohs_pkg::TIME_MAX));
		write_reg(dohs_pkg::REG_TIME_STEP, 32'd0);
		write_reg(dohs_pkg::REG_METHOD_SELECT, 32'(dohs_pkg::METHOD_HEUN));
		write_reg(dohs_pkg::REG_WRITE_PERIOD, 32'd8);
		write_reg(dohs_pkg::REG_SPRING_K, 32'(Q_ONE));
		write_reg(dohs_pkg::REG_DAMPING_GAMMA, 32'd838861);
		push_req(dohs_pkg::CMD_LOAD, 32'sh0040_0000, '0);
		push_steps(5);
		wait_idle();
		write_reg(dohs_pkg::REG_WRITE_PERIOD, 32'd2);
		push_steps(3);
		wait_idle();
		settings_used += 2;

		// Random phases: each rewrites a random subset of registers while idle, then
		// sends mostly load-and-run sequences with some noise mixed in
		while (loads_done + steps_done + steps_ignored < RAND_REQS) begin
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 6; i++) begin
				if ($urandom_range(0, 1) == 1) begin
					case (3'(i))
						dohs_pkg::REG_SPRING_K: begin
							case ($urandom_range(0, 9))
								0: val = 32'(dohs_pkg::WORD_MAX);
								1: val = 32'(dohs_pkg::WORD_MIN);
								2, 3: val = $urandom;
								default: val = $urandom_range(0, 32'h0400_0000);
							endcase
						end
						dohs_pkg::REG_DAMPING_GAMMA: begin
							case ($urandom_range(0, 9))
								0: val = 32'(dohs_pkg::WORD_MAX);
								1: val = 32'(dohs_pkg::WORD_MIN);
								2: val = $urandom;
								default: val = $urandom_range(0, 32'h0080_0000);
							endcase
						end
						dohs_pkg::REG_TIME_STEP: begin
							case ($urandom_range(0, 9))
								0: val = 32'd0;
								1: val = 32'(dohs_pkg::TIME_MAX);
								2: val = $urandom;
								default: val = $urandom_range(1, 32'h0040_0000);
							endcase
						end
						dohs_pkg::REG_END_TIME: begin
							case ($urandom_range(0, 9))
								0: val = 32'd0;
								1: val = 32'(dohs_pkg::TIME_MAX);
								2: val = $urandom;
								3, 4: val = $urandom_range(0, 32'h0800_0000);
								default: val = $urandom_range(32'h0100_0000,
									32'h4000_0000);
							endcase
						end
						dohs_pkg::REG_WRITE_PERIOD: begin
							case ($urandom_range(0, 9))
								0: val = 32'd0;
								1: val = 32'hFFFF;
								2: val = {$urandom_range(0, 32'hFFFF), 16'h0000}
									| 32'd1;
								default: val = $urandom_range(1, 6);
							endcase
						end
						default: val = $urandom;
					endcase
					write_reg(3'(i), val);
				end
			end
			n_seq = $urandom_range(1, 3);
			for (int s = 0; s < n_seq; s++) begin
				if ($urandom_range(0, 99) < 85) begin
					push_req(dohs_pkg::CMD_LOAD, pick_state(), pick_state());
					push_steps($urandom_range(2, 30));
				end else begin
					repeat ($urandom_range(1, 10)) begin
						push_req(1'($urandom), dohs_pkg::word_t'($urandom),
							dohs_pkg::word_t'($urandom));
					end
				end
			end
			wait_idle();
			settings_used++;
		end

		$display("run: %0d loads, %0d steps integrated, %0d steps past the end dropped",
			loads_done, steps_done, steps_ignored);
		$display("run: %0d results checked across %0d register settings, %0d mismatches",
			results_checked, settings_used, mismatches);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
hdl/dohs_pkg.sv
hdl/dohs_mul.sv
hdl/dohs_core.sv
hdl/damped_oscillator_heun_stepper.sv
hdl/dohs_checker.sv
tb/sv/tb.sv
